/* hw/rtl/scwc_pkg.sv */
package scwc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int LEN_WIDTH   = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_WIDTH  = $clog2(MAX_RESULTS + 1);
   localparam int IDX_WIDTH   = $clog2(MAX_RESULTS);

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_LINE   = 3'd2,
      MODE_BODY   = 3'd3,
      MODE_STAR   = 3'd4,
      MODE_STRING = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 byte_valid;
      logic                 end_of_output;
      logic [LEN_WIDTH-1:0] output_length;
   } rsp_type;

   // scan state plus the bytes one input beat produces
   typedef struct packed {
      mode_type                     mode;
      logic                         nl_pending;
      logic                         sp_pending;
      logic [SLOT_WIDTH-1:0]        count;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
   } scan_type;

   function automatic scan_type put_byte(scan_type s, logic [7:0] b);
      scan_type r;
      r = s;
      if (r.count < SLOT_WIDTH'(MAX_RESULTS)) begin
         r.bytes[r.count[IDX_WIDTH-1:0]] = b;
         r.count = r.count + SLOT_WIDTH'(1);
      end
      return r;
   endfunction

   // flush a pending separator, then the byte itself; a quote enters string mode
   function automatic scan_type real_byte(scan_type s, logic [7:0] c);
      scan_type r;
      r = s;
      if (r.nl_pending) begin
         r = put_byte(r, CH_LF);
         r.nl_pending = 1'b0;
         r.sp_pending = 1'b0;
      end else if (r.sp_pending) begin
         r = put_byte(r, CH_SPACE);
         r.sp_pending = 1'b0;
      end
      r = put_byte(r, c);
      if (c == CH_QUOTE) begin
         r.mode = MODE_STRING;
      end
      return r;
   endfunction

   function automatic scan_type scan_normal(scan_type s, logic [7:0] c);
      scan_type r;
      r = s;
      if (c == CH_SLASH) begin
         r.mode = MODE_SLASH;
      end else if (c == CH_LF || c == CH_CR) begin
         r.nl_pending = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
         r.sp_pending = 1'b1;
      end else begin
         r = real_byte(r, c);
      end
      return r;
   endfunction

   function automatic scan_type scan_step(scan_type s, req_type d);
      scan_type   r;
      logic [7:0] c;
      r = s;
      c = d.text_byte;
      if (c != CH_NUL) begin
         case (r.mode)
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  r.mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  r.mode = MODE_STAR;
               end else begin
                  r.mode = MODE_NORMAL;
                  r = real_byte(r, CH_SLASH);
                  r = scan_normal(r, c);
               end
            end
            MODE_LINE: begin
               if (c == CH_LF) begin
                  r.nl_pending = 1'b1;
                  r.mode = MODE_NORMAL;
               end
            end
            MODE_BODY: begin
               if (c == CH_STAR) begin
                  r.mode = MODE_STAR;
               end
            end
            MODE_STAR: begin
               if (c == CH_SLASH) begin
                  r.mode = MODE_NORMAL;
               end else if (c != CH_STAR) begin
                  r.mode = MODE_BODY;
               end
            end
            MODE_STRING: begin
               r = put_byte(r, c);
               if (c == CH_QUOTE) begin
                  r.mode = MODE_NORMAL;
               end
            end
            default: begin
               r.mode = MODE_NORMAL;
               r = scan_normal(r, c);
            end
         endcase
      end
      // a slash still held at the end of the text is a real byte
      if (d.end_of_text && r.mode == MODE_SLASH) begin
         r.mode = MODE_NORMAL;
         r = real_byte(r, CH_SLASH);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/script_comment_whitespace_compressor.sv */
// Script comment stripper and whitespace collapser.
// Input channel req_*: one text byte per beat with an end_of_text flag on the last byte.
// Result channel rsp_*: zero to three beats per input byte, in order. Comments are
// dropped, blank runs become one space, line-break runs one newline, emitted only in
// front of the next real byte. The final input always yields at least one beat; the
// last beat it causes carries end_of_output and the saturating output_length.
// A result beat passes through the input register and then the result group register
// before it is presented.
// Throughput: one input beat per cycle while each produces at most one result beat and
// the receiver does not stall; an input that produces n beats holds the result slot until
// the single result group register has drained them, one beat per cycle while rsp_ready.
// Reset (synchronous, active high) empties both stages and returns the scan to
// normal text with no pending separator and a zero count. After the final input the
// scan returns to the same state by itself.
// When the receiver stalls, the current beat holds unchanged, the input register
// keeps a byte that produces result beats, and req_ready drops once both are occupied; nothing is lost.
module script_comment_whitespace_compressor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scwc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scwc_pkg::rsp_type rsp_data
);
   import scwc_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   req_type                      in_data_ff;

   mode_type                     mode_ff, mode_in;
   logic                         nl_ff, nl_in;
   logic                         sp_ff, sp_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;

   logic                         grp_valid_ff, grp_valid_in;
   logic [IDX_WIDTH-1:0]         idx_ff, idx_in;
   logic [MAX_RESULTS-1:0][7:0]  grp_bytes_ff, grp_bytes_in;
   logic [IDX_WIDTH-1:0]         grp_last_ff, grp_last_in;
   logic                         grp_bval_ff, grp_bval_in;
   logic                         grp_end_ff, grp_end_in;
   logic [LEN_WIDTH-1:0]         grp_len_ff, grp_len_in;

   scan_type                     scan_cur;
   scan_type                     scan_nxt;
   logic [COUNT_WIDTH:0]         count_sum;
   logic [COUNT_WIDTH-1:0]       count_sat;
   logic                         emits;
   logic                         last_beat;
   logic                         grp_done;
   logic                         grp_free;
   logic                         in_adv;
   logic                         req_take;

   always_comb begin
      scan_cur            = '0;
      scan_cur.mode       = mode_ff;
      scan_cur.nl_pending = nl_ff;
      scan_cur.sp_pending = sp_ff;
      scan_nxt            = scan_step(scan_cur, in_data_ff);

      count_sum = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(scan_nxt.count);
      count_sat = count_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : count_sum[COUNT_WIDTH-1:0];
      emits     = (scan_nxt.count != '0) || in_data_ff.end_of_text;
   end

   assign last_beat = (idx_ff == grp_last_ff);
   assign grp_done  = grp_valid_ff && rsp_ready && last_beat;
   assign grp_free  = !grp_valid_ff || grp_done;
   assign in_adv    = in_valid_ff && (grp_free || !emits);
   assign req_ready = !in_valid_ff || in_adv;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_adv) begin
         in_valid_in = 1'b0;
      end

      mode_in  = mode_ff;
      nl_in    = nl_ff;
      sp_in    = sp_ff;
      count_in = count_ff;
      if (in_adv) begin
         if (in_data_ff.end_of_text) begin
            mode_in  = MODE_NORMAL;
            nl_in    = 1'b0;
            sp_in    = 1'b0;
            count_in = '0;
         end else begin
            mode_in  = scan_nxt.mode;
            nl_in    = scan_nxt.nl_pending;
            sp_in    = scan_nxt.sp_pending;
            count_in = count_sat;
         end
      end

      grp_valid_in = grp_valid_ff;
      idx_in       = idx_ff;
      grp_bytes_in = grp_bytes_ff;
      grp_last_in  = grp_last_ff;
      grp_bval_in  = grp_bval_ff;
      grp_end_in   = grp_end_ff;
      grp_len_in   = grp_len_ff;
      if (in_adv && emits) begin
         grp_valid_in = 1'b1;
         idx_in       = '0;
         grp_bytes_in = scan_nxt.bytes;
         grp_bval_in  = (scan_nxt.count != '0);
         grp_last_in  = (scan_nxt.count != '0) ?
                        IDX_WIDTH'(scan_nxt.count - SLOT_WIDTH'(1)) : '0;
         grp_end_in   = in_data_ff.end_of_text;
         if (CMP_WIDTH'(count_sat) > CMP_WIDTH'(LEN_MAX)) begin
            grp_len_in = LEN_MAX;
         end else begin
            grp_len_in = LEN_WIDTH'(count_sat);
         end
      end else if (grp_done) begin
         grp_valid_in = 1'b0;
      end else if (grp_valid_ff && rsp_ready) begin
         // advance to the next beat of the group
         idx_in = idx_ff + IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         nl_ff        <= 1'b0;
         sp_ff        <= 1'b0;
         count_ff     <= '0;
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         nl_ff        <= nl_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      grp_bytes_ff <= grp_bytes_in;
      grp_last_ff  <= grp_last_in;
      grp_bval_ff  <= grp_bval_in;
      grp_end_ff   <= grp_end_in;
      grp_len_ff   <= grp_len_in;
   end

   always_comb begin
      rsp_valid              = grp_valid_ff;
      rsp_data.out_byte      = grp_bytes_ff[idx_ff];
      rsp_data.byte_valid    = grp_bval_ff;
      rsp_data.end_of_output = grp_end_ff && last_beat;
      rsp_data.output_length = (grp_end_ff && last_beat) ? grp_len_ff : '0;
   end

endmodule

/* hw/rtl/scwc_checker.sv */
module scwc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input scwc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scwc_pkg::rsp_type rsp_data
);
   import scwc_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // an end-only beat carries no character
   a_end_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         rsp_data.end_of_output && rsp_data.out_byte == CH_NUL)
      else $error("empty beat is not a clean end marker");

   // the length shows only on the closing beat
   a_len_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.output_length != '0 |-> rsp_data.end_of_output)
      else $error("output length on a beat that does not end the text");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind script_comment_whitespace_compressor scwc_checker u_scwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
